### rtl/core/grol_pkg.sv
// ----------------------------------------------------------------------------
// grol_pkg: shared types and constants of the gyro rate conditioner
// Field widths, rate constants, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package grol_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 24;
	localparam int BIAS_W   = 24;
	localparam int SUM_W    = 26;
	localparam int SEEN_W   = 11;
	localparam int RANGE_W  = 2;
	localparam int GAIN_W   = 17;
	localparam int COUNT_W  = 11;
	localparam int ADDR_W   = 2;
	localparam int DATA_W   = 17;
	localparam int RPL_W    = 23;

	// quotient bits of |sum*256| + n/2
	localparam int DIV_STEPS = 35;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd64;

	// rad/s per lsb, unsigned with 32 fraction bits
	localparam logic [RPL_W-1:0] RPL_250  = 23'd655912;
	localparam logic [RPL_W-1:0] RPL_500  = 23'd1311823;
	localparam logic [RPL_W-1:0] RPL_2000 = 23'd5247293;

	localparam logic [RANGE_W-1:0] RANGE_250  = 2'd0;
	localparam logic [RANGE_W-1:0] RANGE_500  = 2'd1;

	localparam logic [ADDR_W-1:0] CFG_RANGE = 2'd0;
	localparam logic [ADDR_W-1:0] CFG_GAIN  = 2'd1;
	localparam logic [ADDR_W-1:0] CFG_COUNT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILT_MUL,
		ST_FILT_ERR,
		ST_FILT_MUL2,
		ST_FILT_UPD,
		ST_CAL_ACC,
		ST_CAL_CHK,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_STORE,
		ST_RESULT
	} grol_state_t;

	typedef struct packed {
		logic       capture;
		logic       filt_mul;
		logic       filt_err;
		logic       filt_mul2;
		logic       filt_upd;
		logic       cal_acc;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic       load_out;
		logic       updated;
		logic [1:0] axis;
	} grol_cmd_t;

	typedef struct packed {
		logic cal_hit;
		logic out_free;
	} grol_status_t;

	typedef struct packed {
		logic [RPL_W-1:0]  rpl;
		logic [GAIN_W-1:0] gain;
	} grol_coef_t;

	function automatic logic [RPL_W-1:0] rpl_for(input logic [RANGE_W-1:0] range_sel);
		logic [RPL_W-1:0] r;
		case (range_sel)
			RANGE_250: r = RPL_250;
			RANGE_500: r = RPL_500;
			default:   r = RPL_2000;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/grol_in_if.sv
// ----------------------------------------------------------------------------
// grol_in_if: sample channel
// One three-axis raw sample and its mode bit per item.
// ----------------------------------------------------------------------------
interface grol_in_if import grol_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic signed [SAMPLE_W-1:0] sample_x;
	logic signed [SAMPLE_W-1:0] sample_y;
	logic signed [SAMPLE_W-1:0] sample_z;

	modport source (output valid, mode, sample_x, sample_y, sample_z, input ready);
	modport sink   (input valid, mode, sample_x, sample_y, sample_z, output ready);
endinterface

### rtl/core/grol_out_if.sv
// ----------------------------------------------------------------------------
// grol_out_if: result channel
// Filtered three-axis rate and the offset load flag per item.
// ----------------------------------------------------------------------------
interface grol_out_if import grol_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] rate_x;
	logic signed [RATE_W-1:0] rate_y;
	logic signed [RATE_W-1:0] rate_z;
	logic                     offset_updated;

	modport source (output valid, rate_x, rate_y, rate_z, offset_updated, input ready);
	modport sink   (input valid, rate_x, rate_y, rate_z, offset_updated, output ready);
endinterface

### rtl/core/grol_cfg_if.sv
// ----------------------------------------------------------------------------
// grol_cfg_if: register write channel
// Register index and write data per write.
// ----------------------------------------------------------------------------
interface grol_cfg_if import grol_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/core/grol_cfg.sv
// ----------------------------------------------------------------------------
// grol_cfg: configuration registers
// Holds range, gain and calibration count and presents their effective
// values: rate per lsb, gain clamped to one, count clamped to its limits.
// ----------------------------------------------------------------------------
module grol_cfg import grol_pkg::*; #(
	parameter int MAX_CALIB_SAMPLES = 1024,
	parameter int NW = 11
) (
	input  logic            clk,
	input  logic            arst_n,
	grol_cfg_if.sink        cfg,
	output grol_coef_t      coef,
	output logic [NW-1:0]   calib_n
);
	localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

	logic [RANGE_W-1:0] range_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [COUNT_W-1:0] count_q;
	logic [CW-1:0]      count_ext;
	logic [CW-1:0]      n_ext;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_250;
			gain_q  <= GAIN_ONE;
			count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				CFG_RANGE: range_q <= cfg.data[RANGE_W-1:0];
				CFG_GAIN:  gain_q  <= cfg.data[GAIN_W-1:0];
				CFG_COUNT: count_q <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		count_ext = CW'(count_q);
		if (count_ext == '0) begin
			n_ext = CW'(1);
		end else if (count_ext > CW'(MAX_CALIB_SAMPLES)) begin
			n_ext = CW'(MAX_CALIB_SAMPLES);
		end else begin
			n_ext = count_ext;
		end
	end

	assign calib_n   = n_ext[NW-1:0];
	assign coef.rpl  = rpl_for(range_q);
	assign coef.gain = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;

endmodule

### rtl/core/grol_ctrl.sv
// ----------------------------------------------------------------------------
// grol_ctrl: sequencing controller
// Walks the axes through the filter steps or the calibration sum and the
// per-axis offset division, then hands the result to the output register.
// ----------------------------------------------------------------------------
module grol_ctrl import grol_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_mode,
	output logic         in_ready,
	input  grol_status_t status,
	output grol_cmd_t    cmd
);
	grol_state_t       state_q;
	grol_state_t       state_nxt;
	logic [1:0]        axis_q;
	logic [STEP_W-1:0] step_q;
	logic              upd_q;
	logic              last_axis;
	logic              last_step;

	assign last_axis = (axis_q == 2'd2);
	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = in_mode ? ST_CAL_ACC : ST_FILT_MUL;
				end
			end
			ST_FILT_MUL:  state_nxt = ST_FILT_ERR;
			ST_FILT_ERR:  state_nxt = ST_FILT_MUL2;
			ST_FILT_MUL2: state_nxt = ST_FILT_UPD;
			ST_FILT_UPD:  state_nxt = last_axis ? ST_RESULT : ST_FILT_MUL;
			ST_CAL_ACC:   state_nxt = ST_CAL_CHK;
			ST_CAL_CHK:   state_nxt = status.cal_hit ? ST_DIV_LOAD : ST_RESULT;
			ST_DIV_LOAD:  state_nxt = ST_DIV_STEP;
			ST_DIV_STEP: begin
				if (last_step) begin
					state_nxt = ST_DIV_STORE;
				end
			end
			ST_DIV_STORE: state_nxt = last_axis ? ST_RESULT : ST_DIV_LOAD;
			ST_RESULT: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			step_q  <= '0;
			upd_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					axis_q <= '0;
					upd_q  <= 1'b0;
				end
				ST_FILT_UPD,
				ST_DIV_STORE: begin
					axis_q <= axis_q + 2'd1;
				end
				ST_CAL_CHK: begin
					upd_q <= status.cal_hit;
				end
				ST_DIV_LOAD: begin
					step_q <= '0;
				end
				ST_DIV_STEP: begin
					step_q <= step_q + STEP_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.updated   = upd_q;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_FILT_MUL:  cmd.filt_mul  = 1'b1;
			ST_FILT_ERR:  cmd.filt_err  = 1'b1;
			ST_FILT_MUL2: cmd.filt_mul2 = 1'b1;
			ST_FILT_UPD:  cmd.filt_upd  = 1'b1;
			ST_CAL_ACC:   cmd.cal_acc   = 1'b1;
			ST_DIV_LOAD:  cmd.div_load  = 1'b1;
			ST_DIV_STEP:  cmd.div_step  = 1'b1;
			ST_DIV_STORE: cmd.div_store = 1'b1;
			ST_RESULT:    cmd.load_out  = status.out_free;
			default: ;
		endcase
	end

endmodule

### rtl/core/grol_dp.sv
// ----------------------------------------------------------------------------
// grol_dp: arithmetic datapath
// Offset subtract and scale multiplier, low-pass multiplier with saturation,
// calibration sums and a restoring divider for the offsets, output register.
// ----------------------------------------------------------------------------
module grol_dp import grol_pkg::*; #(
	parameter int NW = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  grol_cmd_t                  cmd,
	output grol_status_t               status,
	input  logic signed [SAMPLE_W-1:0] sample_x,
	input  logic signed [SAMPLE_W-1:0] sample_y,
	input  logic signed [SAMPLE_W-1:0] sample_z,
	input  grol_coef_t                 coef,
	input  logic [NW-1:0]              calib_n,
	grol_out_if.source                 rate
);
	localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
	localparam int P1_W = 49;
	localparam int ERR_W = 26;
	localparam int P2_W = 44;
	localparam int STEP_BITS = 28;
	localparam int ACC_W = 29;

	logic signed [SAMPLE_W-1:0] samp_q [3];
	logic signed [RATE_W-1:0]   filt_q [3];
	logic signed [BIAS_W-1:0]   bias_q [3];
	logic signed [SUM_W-1:0]    sum_q  [3];
	logic [SEEN_W-1:0]          seen_q;
	logic                       hit_q;

	logic signed [P1_W-1:0]  prod1_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [P2_W-1:0]  prod2_q;
	logic [DIV_STEPS-1:0]    quo_q;
	logic [NW-1:0]           rem_q;
	logic                    neg_q;

	logic signed [RATE_W-1:0] out_x_q;
	logic signed [RATE_W-1:0] out_y_q;
	logic signed [RATE_W-1:0] out_z_q;
	logic                     out_upd_q;
	logic                     out_valid_q;

	logic signed [SAMPLE_W-1:0]  samp_sel;
	logic signed [RATE_W-1:0]    filt_sel;
	logic signed [BIAS_W-1:0]    bias_sel;
	logic signed [SUM_W-1:0]     sum_sel;
	logic signed [24:0]          diff;
	logic signed [23:0]          rpl_s;
	logic signed [P1_W-1:0]      p1_rnd;
	logic signed [24:0]          scaled;
	logic signed [17:0]          gain_s;
	logic signed [P2_W-1:0]      p2_rnd;
	logic signed [STEP_BITS-1:0] step;
	logic signed [ACC_W-1:0]     acc;
	logic signed [RATE_W-1:0]    filt_new;
	logic [SEEN_W-1:0]           seen_inc;
	logic [33:0]                 num;
	logic [33:0]                 mag;
	logic [NW:0]                 trial;
	logic                        q_bit;
	logic [BIAS_W-1:0]           q_low;

	assign samp_sel = samp_q[cmd.axis];
	assign filt_sel = filt_q[cmd.axis];
	assign bias_sel = bias_q[cmd.axis];
	assign sum_sel  = sum_q[cmd.axis];

	// filter arithmetic
	assign diff   = {samp_sel[SAMPLE_W-1], samp_sel, 8'h00} - {bias_sel[BIAS_W-1], bias_sel};
	assign rpl_s  = {1'b0, coef.rpl};
	assign p1_rnd = prod1_q + P1_W'(64'sd8388608);
	assign scaled = p1_rnd[P1_W-1:24];
	assign gain_s = {1'b0, coef.gain};
	assign p2_rnd = prod2_q + P2_W'(64'sd32768);
	assign step   = p2_rnd[P2_W-1:16];
	assign acc    = step + $signed({{(ACC_W-RATE_W){filt_sel[RATE_W-1]}}, filt_sel});

	always_comb begin
		if (acc[ACC_W-1:RATE_W-1] == '0 || acc[ACC_W-1:RATE_W-1] == '1) begin
			filt_new = acc[RATE_W-1:0];
		end else if (acc[ACC_W-1]) begin
			filt_new = {1'b1, {(RATE_W-1){1'b0}}};
		end else begin
			filt_new = {1'b0, {(RATE_W-1){1'b1}}};
		end
	end

	// calibration arithmetic
	assign seen_inc = seen_q + SEEN_W'(1);
	assign num      = {sum_sel, 8'h00};
	assign mag      = sum_sel[SUM_W-1] ? (34'd0 - num) : num;
	assign trial    = {rem_q, quo_q[DIV_STEPS-1]};
	assign q_bit    = (trial >= {1'b0, calib_n});
	assign q_low    = quo_q[BIAS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				filt_q[i] <= '0;
				bias_q[i] <= '0;
				sum_q[i]  <= '0;
			end
			seen_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (cmd.filt_upd) begin
				filt_q[cmd.axis] <= filt_new;
			end
			if (cmd.cal_acc) begin
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= sum_q[i] + SUM_W'(samp_q[i]);
				end
				// offsets load once the count is reached or passed
				if (CW'(seen_inc) >= CW'(calib_n)) begin
					seen_q <= '0;
					hit_q  <= 1'b1;
				end else begin
					seen_q <= seen_inc;
					hit_q  <= 1'b0;
				end
			end
			if (cmd.div_store) begin
				bias_q[cmd.axis] <= neg_q ? $signed(BIAS_W'(0) - q_low) : $signed(q_low);
				sum_q[cmd.axis]  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			samp_q[0] <= sample_x;
			samp_q[1] <= sample_y;
			samp_q[2] <= sample_z;
		end
		if (cmd.filt_mul) begin
			prod1_q <= diff * rpl_s;
		end
		if (cmd.filt_err) begin
			err_q <= {scaled[24], scaled} - {{2{filt_sel[RATE_W-1]}}, filt_sel};
		end
		if (cmd.filt_mul2) begin
			prod2_q <= err_q * gain_s;
		end
		// rounded mean: (|sum*256| + n/2) / n, one quotient bit per cycle
		if (cmd.div_load) begin
			quo_q <= {1'b0, mag} + DIV_STEPS'(calib_n >> 1);
			rem_q <= '0;
			neg_q <= sum_sel[SUM_W-1];
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? NW'(trial - {1'b0, calib_n}) : trial[NW-1:0];
			quo_q <= {quo_q[DIV_STEPS-2:0], q_bit};
		end
		if (cmd.load_out) begin
			out_x_q   <= filt_q[0];
			out_y_q   <= filt_q[1];
			out_z_q   <= filt_q[2];
			out_upd_q <= cmd.updated;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rate.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.cal_hit  = hit_q;
	assign status.out_free = !out_valid_q || rate.ready;

	assign rate.valid          = out_valid_q;
	assign rate.rate_x         = out_x_q;
	assign rate.rate_y         = out_y_q;
	assign rate.rate_z         = out_z_q;
	assign rate.offset_updated = out_upd_q;

endmodule

### rtl/core/gyro_rate_offset_lowpass.sv
// ----------------------------------------------------------------------------
// gyro_rate_offset_lowpass: gyro offset calibration and low-pass filter
// Three-axis rate conditioner with a controller and a shared datapath.
// ----------------------------------------------------------------------------
// samp carries one raw three-axis sample per item; mode 0 filters it, mode 1
// adds it to the calibration sums. rate returns exactly one item per sample:
// the filtered rates in rad/s (16 fraction bits) and offset_updated.
// cfg writes range_select (0), filter_gain (1) and calib_count (2); it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. One sample is worked at a time. A
// filter sample passes three axes of four steps each through one scale
// multiplier and one gain multiplier. A calibration sample adds to the
// sums; when it completes a run, the restoring divider gives one quotient
// bit per cycle, 35 bits per axis, for the three axes in turn. The result
// sits in an output register, so the next sample is accepted while it
// waits; a stalled receiver holds the block only when a further result is
// ready to be written.
// Reset clears filter state, offsets, sums and count, sets the registers to
// their defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
module gyro_rate_offset_lowpass import grol_pkg::*; #(
	parameter int MAX_CALIB_SAMPLES = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	grol_in_if.sink    samp,
	grol_out_if.source rate,
	grol_cfg_if.sink   cfg
);
	localparam int NW = $clog2(MAX_CALIB_SAMPLES + 1);

	grol_cmd_t    cmd;
	grol_status_t status;
	grol_coef_t   coef;
	logic [NW-1:0] calib_n;
	logic          in_ready;

	assign samp.ready = in_ready;

	grol_cfg #(
		.MAX_CALIB_SAMPLES(MAX_CALIB_SAMPLES),
		.NW(NW)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.coef(coef),
		.calib_n(calib_n)
	);

	grol_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(samp.valid),
		.in_mode(samp.mode),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	grol_dp #(
		.NW(NW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.sample_x(samp.sample_x),
		.sample_y(samp.sample_y),
		.sample_z(samp.sample_z),
		.coef(coef),
		.calib_n(calib_n),
		.rate(rate)
	);

endmodule
